>>> src/tpcs_pkg.sv
`timescale 1ns / 1ps
// Shared widths and constants for the two-phase current smoother.
// Depends on nothing; every other file of the block refers to it.
package tpcs_pkg;

   localparam int RawW = 12;
   localparam int PhaseW = 16;
   localparam int ThirdW = 17;

   localparam int WindowDefault = 5;

   localparam int CodeFull = 4095;
   localparam int Q14One = 16384;

   // floor(w / 5) == (w * BlendMul) >> BlendShift for every w below 2**19.
   localparam int BlendShift = 21;
   localparam int BlendMulW = 19;
   localparam logic [BlendMulW-1:0] BlendMul = 19'd419431;

endpackage

>>> src/tpcs_centre.sv
`timescale 1ns / 1ps
// Centres one 12-bit ADC code to signed Q14 as floor((2*raw - 4095) * 16384 / 4095).
// Depends on tpcs_pkg.
module tpcs_centre (
   input  logic [tpcs_pkg::RawW-1:0]          raw,
   output logic signed [tpcs_pkg::PhaseW-1:0] centred
);

   logic signed [13:0] diff;
   logic signed [15:0] quad;
   logic [14:0]        shifted;
   logic [3:0]         steps;

   // 16384/4095 = 4 + 4/4095, so the result is 4x plus floor(4x/4095), which lies in -4..4.
   always_comb begin
      diff = $signed({1'b0, raw, 1'b0}) - 14'sd4095;
      quad = {diff, 2'b00};
      shifted = 15'(quad + 16'sd16380);
      steps = 4'd0;
      for (int k = 1; k <= 8; k++) begin
         steps = steps + 4'(shifted >= 15'(k * tpcs_pkg::CodeFull));
      end
      centred = tpcs_pkg::PhaseW'(17'(quad) + $signed({13'b0, steps}) - 17'sd4);
   end

endmodule

>>> src/tpcs_ring.sv
`timescale 1ns / 1ps
// Ring of smoothed samples for one phase, with its running sum.
// Each update blends a new centred sample into one slot as floor((4*new + old) / 5).
// Depends on tpcs_pkg.
module tpcs_ring #(
   parameter int Window = tpcs_pkg::WindowDefault,
   parameter int IdxW = (Window > 1) ? $clog2(Window) : 1,
   parameter int SumW = 17 + $clog2(Window)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               update,
   input  logic [IdxW-1:0]                    slot,
   input  logic signed [tpcs_pkg::PhaseW-1:0] fresh,
   output logic signed [SumW-1:0]             sum
);

   logic signed [tpcs_pkg::PhaseW-1:0] ring_ff [Window];
   logic signed [SumW-1:0]             sum_ff;
   logic signed [SumW-1:0]             sum_in;
   logic signed [tpcs_pkg::PhaseW-1:0] old;
   logic signed [18:0]                 mix;
   logic [17:0]                        offs;
   logic [36:0]                        prod;
   logic [15:0]                        quo;
   logic signed [tpcs_pkg::PhaseW-1:0] blended;

   // The blend is taken with an offset of 5*16384 so that the division sees a positive value.
   always_comb begin
      old = ring_ff[slot];
      mix = (19'(fresh) <<< 2) + 19'(old);
      offs = 18'(mix + 19'sd81920);
      prod = 37'(offs) * 37'(tpcs_pkg::BlendMul);
      quo = 16'(prod >> tpcs_pkg::BlendShift);
      blended = tpcs_pkg::PhaseW'(17'(quo) - 17'd16384);
      sum_in = sum_ff - SumW'(old) + SumW'(blended);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Window; i++) begin
            ring_ff[i] <= '0;
         end
         sum_ff <= '0;
      end else if (update) begin
         ring_ff[slot] <= blended;
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

>>> src/tpcs_average.sv
`timescale 1ns / 1ps
// Floor average of a ring sum, by multiplication with a rounded-up reciprocal of the window.
// Depends on tpcs_pkg.
module tpcs_average #(
   parameter int Window = tpcs_pkg::WindowDefault,
   parameter int SumW = 17 + $clog2(Window)
) (
   input  logic signed [SumW-1:0]             sum,
   output logic signed [tpcs_pkg::PhaseW-1:0] average
);

   localparam int RecipShift = SumW + 5;
   localparam int RecipW = RecipShift + 1;
   localparam longint unsigned Recip = ((64'd1 << RecipShift) + Window - 1) / Window;

   logic [SumW-1:0]        offs;
   logic [SumW+RecipW-1:0] prod;
   logic [16:0]            quo;

   always_comb begin
      offs = SumW'(sum + SumW'(tpcs_pkg::Q14One * Window));
      prod = (SumW + RecipW)'(offs) * (SumW + RecipW)'(RecipW'(Recip));
      quo = 17'(prod >> RecipShift);
      average = tpcs_pkg::PhaseW'(quo - 17'd16384);
   end

endmodule

>>> src/two_phase_current_smoother_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Word
// req_      in         req_valid/req_stall  raw_a, raw_b (12-bit ADC codes)
// rsp_      out        rsp_valid/rsp_stall  phase_a, phase_b (Q14), phase_c (17-bit Q14)
// A word passes four register stages: input, centring, ring update with running sum, and
// average, whose register drives the outputs. One word is taken every cycle while req_stall
// is low. The ring update stage sets that rate, touching one slot per phase per cycle.
// Synchronous reset clears the rings, their sums and the slot index. A stalled result holds
// its stage; earlier stages keep taking words until they are full, then req_stall rises.
// Depends on tpcs_pkg, tpcs_centre, tpcs_ring and tpcs_average.
module two_phase_current_smoother_unit #(
   parameter int Window = tpcs_pkg::WindowDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [tpcs_pkg::RawW-1:0]          req_raw_a,
   input  logic [tpcs_pkg::RawW-1:0]          req_raw_b,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [tpcs_pkg::PhaseW-1:0] rsp_phase_a,
   output logic signed [tpcs_pkg::PhaseW-1:0] rsp_phase_b,
   output logic signed [tpcs_pkg::ThirdW-1:0] rsp_phase_c
);

   localparam int IdxW = (Window > 1) ? $clog2(Window) : 1;
   localparam int SumW = 17 + $clog2(Window);

   logic                               in_v_ff, cen_v_ff, sum_v_ff, out_v_ff;
   logic                               in_en, cen_en, sum_en, out_en;
   logic [tpcs_pkg::RawW-1:0]          raw_a_ff, raw_b_ff;
   logic signed [tpcs_pkg::PhaseW-1:0] cen_a_in, cen_b_in;
   logic signed [tpcs_pkg::PhaseW-1:0] cen_a_ff, cen_b_ff;
   logic [IdxW-1:0]                    slot_ff, slot_in;
   logic                               update;
   logic signed [SumW-1:0]             sum_a, sum_b;
   logic signed [tpcs_pkg::PhaseW-1:0] avg_a, avg_b;
   logic signed [tpcs_pkg::ThirdW-1:0] third_in;
   logic signed [tpcs_pkg::PhaseW-1:0] phase_a_ff, phase_b_ff;
   logic signed [tpcs_pkg::ThirdW-1:0] phase_c_ff;

   assign out_en = !out_v_ff || !rsp_stall;
   assign sum_en = !sum_v_ff || out_en;
   assign cen_en = !cen_v_ff || sum_en;
   assign in_en = !in_v_ff || cen_en;
   assign req_stall = !in_en;
   assign update = sum_en && cen_v_ff;

   always_comb begin
      if (slot_ff == IdxW'(Window - 1)) begin
         slot_in = '0;
      end else begin
         slot_in = slot_ff + 1'b1;
      end
   end

   tpcs_centre u_centre_a (.raw(raw_a_ff), .centred(cen_a_in));
   tpcs_centre u_centre_b (.raw(raw_b_ff), .centred(cen_b_in));

   tpcs_ring #(.Window(Window), .IdxW(IdxW), .SumW(SumW)) u_ring_a (
      .clock(clock), .reset(reset), .update(update), .slot(slot_ff),
      .fresh(cen_a_ff), .sum(sum_a)
   );
   tpcs_ring #(.Window(Window), .IdxW(IdxW), .SumW(SumW)) u_ring_b (
      .clock(clock), .reset(reset), .update(update), .slot(slot_ff),
      .fresh(cen_b_ff), .sum(sum_b)
   );

   tpcs_average #(.Window(Window), .SumW(SumW)) u_average_a (.sum(sum_a), .average(avg_a));
   tpcs_average #(.Window(Window), .SumW(SumW)) u_average_b (.sum(sum_b), .average(avg_b));

   assign third_in = -(tpcs_pkg::ThirdW'(avg_a) + tpcs_pkg::ThirdW'(avg_b));

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
         cen_v_ff <= 1'b0;
         sum_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
         slot_ff <= '0;
      end else begin
         if (in_en) begin
            in_v_ff <= req_valid;
         end
         if (cen_en) begin
            cen_v_ff <= in_v_ff;
         end
         if (sum_en) begin
            sum_v_ff <= cen_v_ff;
         end
         if (out_en) begin
            out_v_ff <= sum_v_ff;
         end
         if (update) begin
            slot_ff <= slot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_en) begin
         raw_a_ff <= req_raw_a;
         raw_b_ff <= req_raw_b;
      end
      if (cen_en) begin
         cen_a_ff <= cen_a_in;
         cen_b_ff <= cen_b_in;
      end
      if (out_en) begin
         phase_a_ff <= avg_a;
         phase_b_ff <= avg_b;
         phase_c_ff <= third_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_phase_a = phase_a_ff;
   assign rsp_phase_b = phase_b_ff;
   assign rsp_phase_c = phase_c_ff;

`ifndef SYNTHESIS
   slot_in_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= IdxW'(Window - 1))
      else $error("ring slot index beyond the window");

   stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_v_ff && cen_v_ff && sum_v_ff && out_v_ff))
      else $error("input stalled while the pipeline has a free stage");

   third_phase_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_phase_c == -(tpcs_pkg::ThirdW'(rsp_phase_a)
                                       + tpcs_pkg::ThirdW'(rsp_phase_b))))
      else $error("third phase does not balance the other two");

   phase_a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_phase_a >= -16'sd16384 && rsp_phase_a <= 16'sd16384))
      else $error("phase A average outside the Q14 range");
`endif

endmodule
